/* src/asdc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asdc_pkg
// shared types, constants and helpers for the key schedule decay checker
// ----------------------------------------------------------------------------
package asdc_pkg;

  localparam int ROUND_COUNT_DEF = 11;
  localparam int WORD_W = 32;
  localparam int KEY_W = 128;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TEST = 1'b1;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic valid;
    logic ok;
  } asdc_ctrl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // round constant for rounds 1 to 10, zero elsewhere
  function automatic logic [7:0] rcon(input logic [3:0] round);
    logic [7:0] rc;
    case (round)
      4'd1:    rc = 8'h01;
      4'd2:    rc = 8'h02;
      4'd3:    rc = 8'h04;
      4'd4:    rc = 8'h08;
      4'd5:    rc = 8'h10;
      4'd6:    rc = 8'h20;
      4'd7:    rc = 8'h40;
      4'd8:    rc = 8'h80;
      4'd9:    rc = 8'h1b;
      4'd10:   rc = 8'h36;
      default: rc = 8'h00;
    endcase
    return rc;
  endfunction

  // rotate left by one byte, then s-box on each byte
  function automatic logic [WORD_W-1:0] sub_rot_word(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] r;
    r = {w[23:0], w[31:24]};
    return {SBOX[r[31:24]], SBOX[r[23:16]], SBOX[r[15:8]], SBOX[r[7:0]]};
  endfunction

  // every reference 1 bit must still be 1 in the candidate
  function automatic logic decay_ok(input key_t ref_bits, input key_t cand);
    return (ref_bits & ~cand) == '0;
  endfunction

endpackage

/* src/asdc_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asdc_stage
// one key expansion round plus decay check of the previous round's words
// ----------------------------------------------------------------------------
module asdc_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  asdc_pkg::asdc_ctrl_t ctrl_in,
  input  asdc_pkg::key_t      key_in,
  input  asdc_pkg::key_t      ref_words,
  input  logic [7:0]          rc,
  output asdc_pkg::asdc_ctrl_t ctrl_out,
  output asdc_pkg::key_t      key_out
);

  logic [31:0] t, n0, n1, n2, n3;
  asdc_pkg::key_t key_next;
  logic ok_next;

  always_comb begin
    t  = asdc_pkg::sub_rot_word(key_in[31:0]) ^ {rc, 24'h000000};
    n0 = key_in[127:96] ^ t;
    n1 = key_in[95:64] ^ n0;
    n2 = key_in[63:32] ^ n1;
    n3 = key_in[31:0] ^ n2;
    key_next = {n0, n1, n2, n3};
    ok_next = ctrl_in.ok & asdc_pkg::decay_ok(ref_words, key_in);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else if (en) begin
      ctrl_out.valid <= ctrl_in.valid;
      ctrl_out.ok <= ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      key_out <= key_next;
    end
  end

endmodule

/* src/aes128_schedule_decay_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_schedule_decay_check
// checks a candidate aes-128 key against a stored, decayed key schedule
// ----------------------------------------------------------------------------
// a test item's result reaches m_tvalid through the stage 0 register, one
// stage per expansion round, then the output register
// throughput: one test item or load per cycle while the result register is not
// held; loads are held off while a test is still in the stages that read the schedule
// reset: rst (synchronous) clears all valid bits; the stored schedule is not
// cleared and must be loaded before the first test
module aes128_schedule_decay_check #(
  parameter int ROUND_COUNT = asdc_pkg::ROUND_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [5:0] word_index, [37:6] ref_word, [101:38] key_high, [165:102] key_low
  input  logic [167:0] s_tdata,
  // [0] func
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [0] match
  output logic [7:0]   m_tdata
);

  localparam int WORDS = 4 * ROUND_COUNT;
  localparam int IDX_W = $clog2(WORDS);
  localparam int NST   = ROUND_COUNT - 1;   // expansion stages

  // input fields
  logic [5:0]  word_index;
  logic [31:0] ref_word;
  logic [63:0] key_high;
  logic [63:0] key_low;
  logic        func;

  assign word_index = s_tdata[5:0];
  assign ref_word   = s_tdata[37:6];
  assign key_high   = s_tdata[101:38];
  assign key_low    = s_tdata[165:102];
  assign func       = s_tuser[0];

  // stored reference schedule, one register per word
  logic [31:0] ref_store [WORDS];

  // pipeline: index 0 holds round 0 words, index k holds round k words
  asdc_pkg::asdc_ctrl_t ctrl [NST+1];
  asdc_pkg::key_t       key  [NST+1];
  logic [NST:0]         stage_valid;
  logic                 busy;
  logic                 en;
  logic                 take;
  logic                 load_take;
  logic                 test_take;
  logic                 match_next;
  asdc_pkg::key_t       last_ref;

  // whole pipeline moves unless the result register is held
  assign en = !m_tvalid || m_tready;

  always_comb begin
    for (int k = 0; k <= NST; k++) begin
      stage_valid[k] = ctrl[k].valid;
    end
  end
  assign busy = |stage_valid;

  // a load waits until no test still reads the schedule
  assign s_tready  = en && (func == asdc_pkg::FUNC_TEST || !busy);
  assign take      = s_tvalid && s_tready;
  assign load_take = take && func == asdc_pkg::FUNC_LOAD;
  assign test_take = take && func == asdc_pkg::FUNC_TEST;

  // out-of-range load indexes are dropped
  always_ff @(posedge clk) begin
    if (load_take && {1'b0, word_index} < 7'(WORDS)) begin
      ref_store[word_index[IDX_W-1:0]] <= ref_word;
    end
  end

  // stage 0: capture the key as round 0 words
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl[0] <= '0;
    end else if (en) begin
      ctrl[0].valid <= test_take;
      ctrl[0].ok <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      key[0] <= {key_high, key_low};
    end
  end

  // one stage per expansion round, each also checks the round before it
  for (genvar g = 1; g <= NST; g++) begin : g_round
    asdc_pkg::key_t ref_round;
    assign ref_round = {ref_store[4*(g-1)], ref_store[4*(g-1)+1],
                        ref_store[4*(g-1)+2], ref_store[4*(g-1)+3]};

    asdc_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .ctrl_in   (ctrl[g-1]),
      .key_in    (key[g-1]),
      .ref_words (ref_round),
      .rc        (asdc_pkg::rcon(4'(g))),
      .ctrl_out  (ctrl[g]),
      .key_out   (key[g])
    );
  end

  // last round's words are checked on the way into the result register
  assign last_ref = {ref_store[4*NST], ref_store[4*NST+1],
                     ref_store[4*NST+2], ref_store[4*NST+3]};
  assign match_next = ctrl[NST].ok && asdc_pkg::decay_ok(last_ref, key[NST]);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= ctrl[NST].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {7'b0000000, match_next};
    end
  end

  // a held result register freezes every stage
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(stage_valid))
    else $error("pipeline moved while output stalled");

  // an accepted test enters stage 0
  a_test_enters: assert property (@(posedge clk) disable iff (rst)
    test_take |=> ctrl[0].valid)
    else $error("accepted test lost at stage 0");

  // the last round stage reaches the result register whenever the pipeline moves
  a_reaches_out: assert property (@(posedge clk) disable iff (rst)
    en && ctrl[NST].valid |=> m_tvalid)
    else $error("result dropped at output");

  // schedule never changes under a test in flight
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    load_take |-> !busy && !ctrl[0].valid)
    else $error("load accepted while a test reads the schedule");

endmodule
